// ===== src/hpb_pkg.sv =====
// Shared types and constants of the harmonic power binning block.
// No dependencies; every other file of the block imports this package.
package hpb_pkg;

    localparam int DEF_MAX_BINS = 32;

    localparam int PWR_W      = 32;
    localparam int FREQ_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int QUO_W      = FREQ_W + FRAC_W;
    localparam int F0_W       = 32;
    localparam int TOL_W      = 16;
    localparam int ORD_W      = 6;
    localparam int BIN_W      = 48;
    localparam int HFREQ_W    = 38;
    localparam int CNT_W      = 6;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_PAD_W   = OUT_TDATA_W - ORD_W - BIN_W - HFREQ_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FUNDAMENTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ORDER   = 2'd2;

    localparam logic [F0_W-1:0]  RST_FUNDAMENTAL = 32'd1802240;
    localparam logic [TOL_W-1:0] RST_TOLERANCE   = 16'd3277;
    localparam logic [ORD_W-1:0] RST_MAX_ORDER   = 6'd32;

    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic             add;
        logic [ORD_W-1:0] idx;
        logic [PWR_W-1:0] power;
        logic             final_item;
    } t_op;

endpackage

// ===== src/hpb_front.sv =====
// Front end: accepts partials, divides frequency by f0, rounds and classifies.
// Pushes bin operations into the queue. Depends on hpb_pkg.
module hpb_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [hpb_pkg::F0_W-1:0]   i_fundamental,
    input  logic [hpb_pkg::TOL_W-1:0]  i_tolerance,
    input  logic [hpb_pkg::ORD_W-1:0]  i_limit,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [hpb_pkg::PWR_W-1:0]  i_power,
    input  logic [hpb_pkg::FREQ_W-1:0] i_freq,
    input  logic                       i_last,
    input  logic                       i_q_full,
    output logic                       o_push,
    output hpb_pkg::t_op               o_op
);
    import hpb_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_CLASS = 2'd2;

    logic [1:0]        r_state;
    logic              r_stopped;
    logic [CNT_W-1:0]  r_cnt;
    logic [F0_W-1:0]   r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [PWR_W-1:0]  r_power;
    logic              r_last;

    logic              w_accept;
    logic              w_skip;
    logic [F0_W:0]     w_trial;
    logic [F0_W:0]     w_diff;
    logic              w_ge;
    logic [F0_W:0]     w_order;
    logic [FRAC_W-1:0] w_frac;
    logic [FRAC_W:0]   w_dist;
    logic              w_over;
    logic              w_match;

    assign o_ready  = (r_state == S_IDLE) && !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_skip   = r_stopped || (i_fundamental == '0);

    assign w_trial = {r_rem, r_quo[QUO_W-1]};
    assign w_diff  = w_trial - {1'b0, i_fundamental};
    assign w_ge    = w_trial >= {1'b0, i_fundamental};

    assign w_frac  = r_quo[FRAC_W-1:0];
    assign w_order = {1'b0, r_quo[QUO_W-1:FRAC_W]} + (F0_W+1)'(w_frac[FRAC_W-1]);
    assign w_dist  = w_frac[FRAC_W-1] ? ((FRAC_W+1)'(1) << FRAC_W) - {1'b0, w_frac}
                                      : {1'b0, w_frac};
    assign w_over  = w_order > (F0_W+1)'(i_limit);
    assign w_match = !w_over && (w_order != '0) && (w_dist <= (FRAC_W+1)'(i_tolerance));

    always_comb begin
        o_push = 1'b0;
        o_op   = '0;
        if (r_state == S_IDLE) begin
            o_push          = w_accept && w_skip && i_last;
            o_op.power      = i_power;
            o_op.final_item = 1'b1;
        end else if (r_state == S_CLASS) begin
            o_push          = w_match || r_last;
            o_op.add        = w_match;
            o_op.idx        = ORD_W'(w_order - (F0_W+1)'(1));
            o_op.power      = r_power;
            o_op.final_item = r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_stopped <= 1'b0;
            r_cnt     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cnt <= '0;
                        if (w_skip) begin
                            r_stopped <= !i_last;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(QUO_W - 1)) begin
                        r_state <= S_CLASS;
                    end
                end
                S_CLASS: begin
                    r_stopped <= w_over && !r_last;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            if (w_accept) begin
                r_power <= i_power;
                r_last  <= i_last;
                r_rem   <= '0;
                r_quo   <= {i_freq, FRAC_W'(0)};
            end
        end else if (r_state == S_DIV) begin
            r_rem <= w_ge ? w_diff[F0_W-1:0] : w_trial[F0_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

endmodule

// ===== src/hpb_queue.sv =====
// Short queue of bin operations between front and back end.
// Depends on hpb_pkg for the operation type and depth.
module hpb_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  hpb_pkg::t_op i_op,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output hpb_pkg::t_op o_op
);
    import hpb_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_op           r_mem [Q_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_count;

    assign o_full  = r_count == CW'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_op    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= (r_wp == PW'(Q_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop && !o_empty) begin
                r_rp <= (r_rp == PW'(Q_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            r_count <= r_count + CW'(i_push && !o_full) - CW'(i_pop && !o_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_op;
        end
    end

endmodule

// ===== src/hpb_back.sv =====
// Back end: bin memory with read-modify-write update, saturating sums,
// and the emit sequencer with its output register. Depends on hpb_pkg.
module hpb_back #(
    parameter int MAX_BINS = hpb_pkg::DEF_MAX_BINS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [hpb_pkg::F0_W-1:0]    i_fundamental,
    input  logic [hpb_pkg::ORD_W-1:0]   i_limit,
    input  logic                        i_q_empty,
    input  hpb_pkg::t_op                i_op,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hpb_pkg::ORD_W-1:0]   o_order,
    output logic [hpb_pkg::BIN_W-1:0]   o_power,
    output logic [hpb_pkg::HFREQ_W-1:0] o_hfreq,
    output logic                        o_last
);
    import hpb_pkg::*;

    localparam int IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADD_RD = 3'd1;
    localparam logic [2:0] S_ADD_WR = 3'd2;
    localparam logic [2:0] S_EM_RD  = 3'd3;
    localparam logic [2:0] S_EM_OUT = 3'd4;

    logic [BIN_W-1:0]    r_bins [MAX_BINS];
    logic [MAX_BINS-1:0] r_bin_vld;
    logic [2:0]          r_state;
    t_op                 r_op;
    logic [BIN_W-1:0]    r_rd_data;
    logic                r_rd_vld;
    logic [IW-1:0]       r_k;
    logic [ORD_W-1:0]    r_ord;
    logic [HFREQ_W-1:0]  r_hfreq;
    logic                r_out_valid;
    logic [ORD_W-1:0]    r_out_order;
    logic [BIN_W-1:0]    r_out_power;
    logic [HFREQ_W-1:0]  r_out_hfreq;
    logic                r_out_last;

    logic                w_rd_en;
    logic [IW-1:0]       w_rd_addr;
    logic [IW-1:0]       w_wr_addr;
    logic                w_wr_en;
    logic [BIN_W-1:0]    w_cur;
    logic [BIN_W:0]      w_sum;
    logic [BIN_W-1:0]    w_sat;
    logic                w_load;
    logic                w_emit_last;
    logic                w_start;

    assign o_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign w_rd_en   = (r_state == S_ADD_RD) || (r_state == S_EM_RD);
    assign w_rd_addr = (r_state == S_ADD_RD) ? r_op.idx[IW-1:0] : r_k;
    assign w_wr_addr = r_op.idx[IW-1:0];
    assign w_wr_en   = r_state == S_ADD_WR;
    assign w_cur     = r_rd_vld ? r_rd_data : '0;
    assign w_sum     = {1'b0, w_cur} + (BIN_W+1)'(r_op.power);
    assign w_sat     = w_sum[BIN_W] ? {BIN_W{1'b1}} : w_sum[BIN_W-1:0];
    assign w_load    = (r_state == S_EM_OUT) && (!r_out_valid || i_ready);
    assign w_emit_last = r_ord == i_limit;
    assign w_start   = ((r_state == S_ADD_WR) && r_op.final_item) ||
                       (o_pop && !i_op.add && i_op.final_item);

    assign o_valid = r_out_valid;
    assign o_order = r_out_order;
    assign o_power = r_out_power;
    assign o_hfreq = r_out_hfreq;
    assign o_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_bins[w_rd_addr];
            r_rd_vld  <= r_bin_vld[w_rd_addr];
        end
        if (w_wr_en) begin
            r_bins[w_wr_addr] <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bin_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop && i_op.add) begin
                        r_state <= S_ADD_RD;
                    end else if (w_start) begin
                        if (i_limit == '0) begin
                            r_bin_vld <= '0;
                        end else begin
                            r_state <= S_EM_RD;
                        end
                    end
                end
                S_ADD_RD: begin
                    r_state <= S_ADD_WR;
                end
                S_ADD_WR: begin
                    if (!w_start) begin
                        r_bin_vld[w_wr_addr] <= 1'b1;
                        r_state              <= S_IDLE;
                    end else if (i_limit == '0) begin
                        r_bin_vld <= '0;
                        r_state   <= S_IDLE;
                    end else begin
                        r_bin_vld[w_wr_addr] <= 1'b1;
                        r_state              <= S_EM_RD;
                    end
                end
                S_EM_RD: begin
                    r_state <= S_EM_OUT;
                end
                S_EM_OUT: begin
                    if (w_load) begin
                        if (w_emit_last) begin
                            r_bin_vld <= '0;
                            r_state   <= S_IDLE;
                        end else begin
                            r_state <= S_EM_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_op;
        end
        if (w_start) begin
            r_k     <= '0;
            r_ord   <= ORD_W'(1);
            r_hfreq <= HFREQ_W'(i_fundamental);
        end else if (w_load && !w_emit_last) begin
            r_k     <= r_k + IW'(1);
            r_ord   <= r_ord + ORD_W'(1);
            r_hfreq <= r_hfreq + HFREQ_W'(i_fundamental);
        end
        if (w_load) begin
            r_out_order <= r_ord;
            r_out_power <= w_cur;
            r_out_hfreq <= r_hfreq;
            r_out_last  <= w_emit_last;
        end
    end

endmodule

// ===== src/harmonic_power_binning_top.sv =====
// Channel     Dir  Handshake               Payload
// s_axis      in   tvalid/tready           tdata{power,frequency}, tlast=final partial
// m_axis      out  tvalid/tready           tdata{order,bin power,harmonic freq}, tlast=last bin
// cfg         in   we                      index, data (fundamental, tolerance, max_order)
// In the front end a partial passes the 48-step radix-2 divider, then classification;
// a partial arriving while the set is stopped, or with zero f0, skips the divider.
// The back end runs pop, read and write states per bin update, read and output per emitted bin.
// Reset is synchronous; bin contents are cleared through per-bin valid flags.
// A stalled output holds the back end; the queue lets the front keep accepting until it is full.
module harmonic_power_binning_top #(
    parameter int MAX_BINS = hpb_pkg::DEF_MAX_BINS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [31:0] partial_power, [63:32] partial_frequency
    input  logic [hpb_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                            i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [5:0] harmonic_order, [53:6] bin_power, [91:54] harmonic_frequency, [95:92] zero
    output logic [hpb_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                            o_m_axis_tlast,
    input  logic                            i_cfg_we,
    input  logic [hpb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hpb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import hpb_pkg::*;

    logic [F0_W-1:0]    r_fundamental;
    logic [TOL_W-1:0]   r_tolerance;
    logic [ORD_W-1:0]   r_max_order;
    logic [ORD_W-1:0]   w_limit;

    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;
    t_op                w_push_op;
    t_op                w_pop_op;
    logic [ORD_W-1:0]   w_order;
    logic [BIN_W-1:0]   w_power;
    logic [HFREQ_W-1:0] w_hfreq;

    assign w_limit = ({1'b0, r_max_order} > (ORD_W+1)'(MAX_BINS)) ? ORD_W'(MAX_BINS)
                                                                 : r_max_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fundamental <= RST_FUNDAMENTAL;
            r_tolerance   <= RST_TOLERANCE;
            r_max_order   <= RST_MAX_ORDER;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FUNDAMENTAL: r_fundamental <= i_cfg_data[F0_W-1:0];
                CFG_TOLERANCE:   r_tolerance   <= i_cfg_data[TOL_W-1:0];
                CFG_MAX_ORDER:   r_max_order   <= i_cfg_data[ORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    hpb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fundamental (r_fundamental),
        .i_tolerance   (r_tolerance),
        .i_limit       (w_limit),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_power       (i_s_axis_tdata[PWR_W-1:0]),
        .i_freq        (i_s_axis_tdata[PWR_W+FREQ_W-1:PWR_W]),
        .i_last        (i_s_axis_tlast),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_op          (w_push_op)
    );

    hpb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_op    (w_pop_op)
    );

    hpb_back #(
        .MAX_BINS (MAX_BINS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fundamental (r_fundamental),
        .i_limit       (w_limit),
        .i_q_empty     (w_empty),
        .i_op          (w_pop_op),
        .o_pop         (w_pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_order       (w_order),
        .o_power       (w_power),
        .o_hfreq       (w_hfreq),
        .o_last        (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {OUT_PAD_W'(0), w_hfreq, w_power, w_order};

endmodule
